// File: design/postfix_expression_evaluator_unit_macros.svh
// ----------------------------------------------------------------------------
// postfix expression evaluator - assertion macros
// shared concurrent assertion forms used by the checker
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PEVU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PEVU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pevu_pkg.sv
// ----------------------------------------------------------------------------
// pevu_pkg
// types, codes and constants of the postfix expression evaluator
// ----------------------------------------------------------------------------
package pevu_pkg;

    // field widths
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned VALUE_W  = 8;
    localparam int unsigned BAL_W    = 32;
    localparam int unsigned CNT_W    = $clog2(DATA_W);

    // default operand stack depth
    localparam int unsigned STACK_DEPTH_DEF = 16;

    // operator character codes
    localparam logic [VALUE_W-1:0] CODE_ADD = 8'd43;
    localparam logic [VALUE_W-1:0] CODE_SUB = 8'd45;
    localparam logic [VALUE_W-1:0] CODE_MUL = 8'd42;
    localparam logic [VALUE_W-1:0] CODE_DIV = 8'd47;

    // completion status
    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_UNDERFLOW   = 3'd1,
        STATUS_UNSUPPORTED = 3'd2,
        STATUS_DIVZERO     = 3'd3,
        STATUS_OVERFLOW    = 3'd4
    } status_t;

    // input transaction
    typedef struct packed {
        logic                      op;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } cmd_t;

    // result transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        status_t                  status;
        logic                     well_formed;
    } rsp_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FETCH,
        S_EXEC,
        S_DONE
    } ctl_state_t;

    // serial arithmetic unit
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef enum logic [1:0] {
        A_IDLE,
        A_RUN,
        A_FIX
    } alu_state_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

endpackage

// File: design/pevu_stack.sv
// ----------------------------------------------------------------------------
// pevu_stack
// operand stack storage: one write port, one registered read port
// ----------------------------------------------------------------------------
module pevu_stack #(
    parameter int unsigned DEPTH = pevu_pkg::STACK_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [pevu_pkg::DATA_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [pevu_pkg::DATA_W-1:0] rdata
);

    logic [pevu_pkg::DATA_W-1:0] mem_reg [DEPTH];
    logic [pevu_pkg::DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/pevu_alu.sv
// ----------------------------------------------------------------------------
// pevu_alu
// serial arithmetic unit: bit-serial add/sub, shift-add multiply and
// restoring divide, one bit per cycle
// ----------------------------------------------------------------------------
module pevu_alu (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pevu_pkg::alu_ctl_t          ctl,
    input  logic [pevu_pkg::DATA_W-1:0] a,
    input  logic [pevu_pkg::DATA_W-1:0] b,
    output logic                        done,
    output logic [pevu_pkg::DATA_W-1:0] res
);

    localparam int unsigned DW = pevu_pkg::DATA_W;
    localparam int unsigned CW = pevu_pkg::CNT_W;

    pevu_pkg::alu_state_t state_reg, state_next;
    pevu_pkg::alu_op_t    op_reg, op_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [DW-1:0]        x_reg, x_next;
    logic [DW-1:0]        y_reg, y_next;
    logic [DW-1:0]        acc_reg, acc_next;
    logic                 carry_reg, carry_next;
    logic                 neg_reg, neg_next;
    logic [DW-1:0]        res_reg, res_next;
    logic                 done_reg, done_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pevu_pkg::A_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = pevu_pkg::A_RUN;
                end
            end
            pevu_pkg::A_RUN:
            begin
                if (cnt_reg == CW'(DW - 1))
                begin
                    state_next = pevu_pkg::A_FIX;
                end
            end
            pevu_pkg::A_FIX:
            begin
                state_next = pevu_pkg::A_IDLE;
            end
            default:
            begin
                state_next = pevu_pkg::A_IDLE;
            end
        endcase
    end

    // completion flag
    always_comb
    begin
        done_next = (state_reg == pevu_pkg::A_FIX);
    end

    // datapath
    always_comb
    begin
        logic          sum_bit;
        logic [DW:0]   shifted;
        logic [DW:0]   diff;
        logic          q_bit;

        op_next    = op_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        carry_next = carry_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        sum_bit    = 1'b0;
        shifted    = {acc_reg, x_reg[DW-1]};
        diff       = shifted - {1'b0, y_reg};
        q_bit      = ~diff[DW];

        case (state_reg)
            pevu_pkg::A_IDLE:
            begin
                if (ctl.start)
                begin
                    op_next    = ctl.op;
                    cnt_next   = '0;
                    acc_next   = '0;
                    carry_next = (ctl.op == pevu_pkg::ALU_SUB);
                    neg_next   = a[DW-1] ^ b[DW-1];
                    x_next     = a;
                    y_next     = b;
                    // invert subtrahend, carry-in supplies the +1
                    if (ctl.op == pevu_pkg::ALU_SUB)
                    begin
                        y_next = ~b;
                    end
                    // divide works on magnitudes
                    if (ctl.op == pevu_pkg::ALU_DIV)
                    begin
                        x_next = a[DW-1] ? (~a + DW'(1)) : a;
                        y_next = b[DW-1] ? (~b + DW'(1)) : b;
                    end
                end
            end
            pevu_pkg::A_RUN:
            begin
                cnt_next = cnt_reg + CW'(1);
                case (op_reg)
                    pevu_pkg::ALU_ADD, pevu_pkg::ALU_SUB:
                    begin
                        // one sum bit per cycle, lsb first
                        sum_bit    = x_reg[0] ^ y_reg[0] ^ carry_reg;
                        carry_next = (x_reg[0] & y_reg[0]) |
                                     (carry_reg & (x_reg[0] ^ y_reg[0]));
                        x_next     = {1'b0, x_reg[DW-1:1]};
                        y_next     = {1'b0, y_reg[DW-1:1]};
                        acc_next   = {sum_bit, acc_reg[DW-1:1]};
                    end
                    pevu_pkg::ALU_MUL:
                    begin
                        // shift-add on one multiplier bit
                        if (y_reg[0])
                        begin
                            acc_next = acc_reg + x_reg;
                        end
                        x_next = {x_reg[DW-2:0], 1'b0};
                        y_next = {1'b0, y_reg[DW-1:1]};
                    end
                    pevu_pkg::ALU_DIV:
                    begin
                        // restoring step: remainder in acc, quotient into x
                        if (q_bit)
                        begin
                            acc_next = diff[DW-1:0];
                        end
                        else
                        begin
                            acc_next = shifted[DW-1:0];
                        end
                        x_next = {x_reg[DW-2:0], q_bit};
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
            pevu_pkg::A_FIX:
            begin
                // sign correction of the quotient on divide, else the accumulator as result
                if (op_reg == pevu_pkg::ALU_DIV)
                begin
                    res_next = neg_reg ? (~x_reg + DW'(1)) : x_reg;
                end
                else
                begin
                    res_next = acc_reg;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pevu_pkg::A_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            op_reg    <= pevu_pkg::ALU_ADD;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
        end
    end

    // shift registers and result
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        carry_reg <= carry_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: design/postfix_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// evaluates one postfix integer expression per run of command transactions
// ----------------------------------------------------------------------------
// cmd channel (cmd_valid/cmd_stall/cmd): one transaction per number or
// operator; cmd.last closes the expression. rsp channel (rsp_valid/
// rsp_stall/rsp): one transaction per expression with result, status and
// the well-formed flag.
// items are handled one at a time. a push, or any item that raises or meets
// an error, passes from acceptance through dispatch and done back to idle;
// an operator that runs also passes operand fetch and the serial arithmetic
// unit's 32 bit steps, sign correction and its done flag, with write-back
// into the stack as the unit finishes, before done and the return to idle.
// the result transaction is registered when a closing item, after any
// arithmetic that it runs, reaches done with the output register free.
// a held result sits in the output register while the next expression is
// taken in; only a second finished expression waits for it, stalling cmd.
// reset empties the stack and clears status and balance; stack storage
// keeps its contents but entries above the depth are never read.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit #(
    parameter int unsigned STACK_DEPTH = pevu_pkg::STACK_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  pevu_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output pevu_pkg::rsp_t rsp
);

    localparam int unsigned AW  = $clog2(STACK_DEPTH);
    localparam int unsigned DPW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned DW  = pevu_pkg::DATA_W;
    localparam int unsigned VW  = pevu_pkg::VALUE_W;
    localparam int unsigned BW  = pevu_pkg::BAL_W;

    pevu_pkg::ctl_state_t state_reg, state_next;
    pevu_pkg::cmd_t       cmd_reg, cmd_next;
    logic [DPW-1:0]       depth_reg, depth_next;
    pevu_pkg::status_t    err_reg, err_next;
    logic                 bal_bad_reg, bal_bad_next;
    logic [BW-1:0]        bal_cnt_reg, bal_cnt_next;
    logic [DW-1:0]        tos_reg, tos_next;
    pevu_pkg::rsp_t       rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DW-1:0]        mem_wdata;
    logic                 mem_re;
    logic [DW-1:0]        mem_rdata;
    pevu_pkg::alu_ctl_t   alu_ctl;
    logic                 alu_done;
    logic [DW-1:0]        alu_res;

    logic [DPW-1:0]       depth_m2;
    logic                 is_add, is_sub, is_mul, is_div, code_ok;
    logic                 short_stack, div_zero, go_op, stack_full;
    logic                 rsp_free;
    pevu_pkg::alu_op_t    alu_op;

    // operator decode
    assign is_add      = ($unsigned(cmd_reg.value) == pevu_pkg::CODE_ADD);
    assign is_sub      = ($unsigned(cmd_reg.value) == pevu_pkg::CODE_SUB);
    assign is_mul      = ($unsigned(cmd_reg.value) == pevu_pkg::CODE_MUL);
    assign is_div      = ($unsigned(cmd_reg.value) == pevu_pkg::CODE_DIV);
    assign code_ok     = is_add | is_sub | is_mul | is_div;
    assign depth_m2    = depth_reg - DPW'(2);
    assign short_stack = (depth_reg < DPW'(2));
    assign stack_full  = (depth_reg >= DPW'(STACK_DEPTH));
    assign div_zero    = is_div & (tos_reg == '0);
    assign go_op       = (err_reg == pevu_pkg::STATUS_OK) & cmd_reg.op &
                         ~short_stack & code_ok & ~div_zero;
    assign rsp_free    = ~rsp_valid_reg | ~rsp_stall;

    always_comb
    begin
        case (1'b1)
            is_sub:  alu_op = pevu_pkg::ALU_SUB;
            is_mul:  alu_op = pevu_pkg::ALU_MUL;
            is_div:  alu_op = pevu_pkg::ALU_DIV;
            default: alu_op = pevu_pkg::ALU_ADD;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pevu_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = pevu_pkg::S_DISPATCH;
                end
            end
            pevu_pkg::S_DISPATCH:
            begin
                state_next = go_op ? pevu_pkg::S_FETCH : pevu_pkg::S_DONE;
            end
            pevu_pkg::S_FETCH:
            begin
                state_next = pevu_pkg::S_EXEC;
            end
            pevu_pkg::S_EXEC:
            begin
                if (alu_done)
                begin
                    state_next = pevu_pkg::S_DONE;
                end
            end
            pevu_pkg::S_DONE:
            begin
                if (!cmd_reg.last || rsp_free)
                begin
                    state_next = pevu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pevu_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs: handshake, stack ports, arithmetic start
    always_comb
    begin
        cmd_stall     = (state_reg != pevu_pkg::S_IDLE);
        mem_re        = (state_reg == pevu_pkg::S_DISPATCH) && go_op;
        alu_ctl.start = (state_reg == pevu_pkg::S_FETCH);
        alu_ctl.op    = alu_op;
        mem_we        = 1'b0;
        mem_waddr     = depth_reg[AW-1:0];
        mem_wdata     = {{(DW - VW){cmd_reg.value[VW-1]}}, cmd_reg.value};
        case (state_reg)
            pevu_pkg::S_DISPATCH:
            begin
                mem_we = (err_reg == pevu_pkg::STATUS_OK) && !cmd_reg.op &&
                         !stack_full;
            end
            pevu_pkg::S_EXEC:
            begin
                mem_we    = alu_done;
                mem_waddr = depth_m2[AW-1:0];
                mem_wdata = alu_res;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // expression state and result register
    always_comb
    begin
        cmd_next       = cmd_reg;
        depth_next     = depth_reg;
        err_next       = err_reg;
        bal_bad_next   = bal_bad_reg;
        bal_cnt_next   = bal_cnt_reg;
        tos_next       = tos_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;

        case (state_reg)
            pevu_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    // running balance: +1 per number, -1 per operator
                    if (cmd.op)
                    begin
                        if (bal_cnt_reg == BW'(0) || bal_cnt_reg == BW'(1))
                        begin
                            bal_bad_next = 1'b1;
                        end
                        if (bal_cnt_reg != BW'(0))
                        begin
                            bal_cnt_next = bal_cnt_reg - BW'(1);
                        end
                    end
                    else
                    begin
                        if (&bal_cnt_reg)
                        begin
                            bal_bad_next = 1'b1;
                        end
                        else
                        begin
                            bal_cnt_next = bal_cnt_reg + BW'(1);
                        end
                    end
                end
            end
            pevu_pkg::S_DISPATCH:
            begin
                if (err_reg == pevu_pkg::STATUS_OK)
                begin
                    if (!cmd_reg.op)
                    begin
                        if (stack_full)
                        begin
                            err_next = pevu_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            depth_next = depth_reg + DPW'(1);
                            tos_next   = mem_wdata;
                        end
                    end
                    else if (short_stack)
                    begin
                        err_next = pevu_pkg::STATUS_UNDERFLOW;
                    end
                    else if (!code_ok)
                    begin
                        err_next = pevu_pkg::STATUS_UNSUPPORTED;
                    end
                    else if (div_zero)
                    begin
                        err_next = pevu_pkg::STATUS_DIVZERO;
                    end
                end
            end
            pevu_pkg::S_EXEC:
            begin
                if (alu_done)
                begin
                    depth_next = depth_reg - DPW'(1);
                    tos_next   = alu_res;
                end
            end
            pevu_pkg::S_DONE:
            begin
                if (cmd_reg.last && rsp_free)
                begin
                    rsp_next.result      = ((err_reg == pevu_pkg::STATUS_OK) &&
                                            (depth_reg != '0)) ? tos_reg : '0;
                    rsp_next.status      = err_reg;
                    rsp_next.well_formed = !bal_bad_reg && (bal_cnt_reg == BW'(1));
                    rsp_valid_next       = 1'b1;
                    // clear per-expression state
                    depth_next           = '0;
                    err_next             = pevu_pkg::STATUS_OK;
                    bal_bad_next         = 1'b0;
                    bal_cnt_next         = '0;
                end
            end
            default:
            begin
                cmd_next = cmd_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pevu_pkg::S_IDLE;
            depth_reg     <= '0;
            err_reg       <= pevu_pkg::STATUS_OK;
            bal_bad_reg   <= 1'b0;
            bal_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            bal_bad_reg   <= bal_bad_next;
            bal_cnt_reg   <= bal_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        tos_reg <= tos_next;
        rsp_reg <= rsp_next;
    end

    // operand stack, second entry from the top is read for operators
    pevu_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (depth_m2[AW-1:0]),
        .rdata (mem_rdata)
    );

    // serial arithmetic: a is second from top, b is the top
    pevu_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (alu_ctl),
        .a     (mem_rdata),
        .b     (tos_reg),
        .done  (alu_done),
        .res   (alu_res)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: design/pevu_checker.sv
// ----------------------------------------------------------------------------
// pevu_checker
// port-level assertions for the postfix expression evaluator
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_unit_macros.svh"

module pevu_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_stall,
    input pevu_pkg::cmd_t cmd,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input pevu_pkg::rsp_t rsp
);

    // a stalled result transaction holds
    `PEVU_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

    // an error result carries a zero value
    `PEVU_ASSERT_IMP(a_err_zero, clk, rst_n, rsp_valid && rsp.status != pevu_pkg::STATUS_OK, rsp.result == '0, "error result not zero")

    // items are taken one at a time
    `PEVU_ASSERT_NXT(a_busy_after_accept, clk, rst_n, cmd_valid && !cmd_stall, cmd_stall, "item taken while busy")

    // a new result only appears while an item is being processed
    `PEVU_ASSERT_IMP(a_rsp_from_busy, clk, rst_n, $rose(rsp_valid), $past(cmd_stall), "result without work")

endmodule

bind postfix_expression_evaluator_unit pevu_checker u_pevu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// File: bench/tb_postfix_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator_unit
// self-checking bench for the postfix expression evaluator
// ----------------------------------------------------------------------------
// a queue of command transactions is built up front: a short directed set
// (all four operators, extreme operands, most negative over minus one,
// underflow, unknown operator with sticky error, zero divisor), then random
// expressions, mostly well formed with random operands, some deep enough to
// overflow the stack, some corrupted and some pure noise. an internal
// evaluator predicts each result transaction when the closing command is
// accepted; results are checked in order, field by field. both channels
// idle at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import pevu_pkg::*;

    localparam int unsigned DEPTH        = STACK_DEPTH_DEF;
    localparam int unsigned RANDOM_ITEMS = 1650;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 64;

    logic clk;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // stimulus and expectations
    cmd_t pending_tokens[$];
    rsp_t expected_answers[$];
    logic cmd_fire = 1'b0;
    int unsigned send_gap  = 0;
    int unsigned hold_left = 0;

    // bookkeeping
    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;
    int unsigned tokens_taken = 0;
    int unsigned answers_checked = 0;
    int unsigned directed_count;
    int unsigned status_seen[5] = '{default: 0};

    // evaluator state
    logic [DATA_W-1:0] eval_stack[DEPTH];
    int unsigned       eval_depth;
    status_t           eval_err;
    bit                eval_bal_bad;
    logic [BAL_W-1:0]  eval_balance;

    postfix_expression_evaluator_unit #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // per-expression state back to empty
    function automatic void clear_eval();
        foreach (eval_stack[i])
            eval_stack[i] = '0;
        eval_depth   = 0;
        eval_err     = STATUS_OK;
        eval_bal_bad = 1'b0;
        eval_balance = '0;
    endfunction

    // apply one command to the evaluator, returning the answer on a closing one
    function automatic void evaluate_token(input cmd_t tok, output bit closes,
                                           output rsp_t answer);
        logic [DATA_W-1:0] lhs, rhs, res, mag_l, mag_r, quo;
        bit                applied;
        closes = 1'b0;
        answer = '0;
        if (tok.op)
        begin
            // balance check, then the operator unless an error is pending
            if (eval_balance <= 1)
                eval_bal_bad = 1'b1;
            if (eval_balance != 0)
                eval_balance = eval_balance - 1;
            if (eval_err == STATUS_OK)
            begin
                if (eval_depth < 2)
                    eval_err = STATUS_UNDERFLOW;
                else
                begin
                    rhs     = eval_stack[eval_depth-1];
                    lhs     = eval_stack[eval_depth-2];
                    res     = '0;
                    applied = 1'b1;
                    case ($unsigned(tok.value))
                        CODE_ADD: res = lhs + rhs;
                        CODE_SUB: res = lhs - rhs;
                        CODE_MUL: res = lhs * rhs;
                        CODE_DIV:
                        begin
                            if (rhs == '0)
                            begin
                                eval_err = STATUS_DIVZERO;
                                applied  = 1'b0;
                            end
                            else
                            begin
                                // magnitudes, then sign; truncates toward zero
                                mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                                mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                                quo   = mag_l / mag_r;
                                res   = (lhs[DATA_W-1] != rhs[DATA_W-1]) ? -quo : quo;
                            end
                        end
                        default:
                        begin
                            eval_err = STATUS_UNSUPPORTED;
                            applied  = 1'b0;
                        end
                    endcase
                    if (applied)
                    begin
                        eval_depth = eval_depth - 1;
                        eval_stack[eval_depth-1] = res;
                    end
                end
            end
        end
        else
        begin
            // push, balance saturates at its top
            if (eval_balance == '1)
                eval_bal_bad = 1'b1;
            else
                eval_balance = eval_balance + 1;
            if (eval_err == STATUS_OK)
            begin
                if (eval_depth >= DEPTH)
                    eval_err = STATUS_OVERFLOW;
                else
                begin
                    eval_stack[eval_depth] = {{(DATA_W-VALUE_W){tok.value[VALUE_W-1]}},
                                              tok.value};
                    eval_depth = eval_depth + 1;
                end
            end
        end
        if (tok.last)
        begin
            closes = 1'b1;
            answer.result = (eval_err == STATUS_OK && eval_depth != 0) ?
                            eval_stack[eval_depth-1] : '0;
            answer.status      = eval_err;
            answer.well_formed = !eval_bal_bad && eval_balance == 1;
            clear_eval();
        end
    endfunction

    // idle length: mostly none or short, a few long, none in quiet stretches
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (((cycle_count >> 11) % 4) == 3)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_token(input logic op, input logic [VALUE_W-1:0] value,
                             input logic last);
        cmd_t tok;
        tok.op    = op;
        tok.value = value;
        tok.last  = last;
        pending_tokens.push_back(tok);
    endtask

    // one random expression: noise, well formed, deep, or corrupted
    task automatic add_random_expression();
        cmd_t        seq[$];
        cmd_t        tok;
        int unsigned mode, r, pushes, depth, idx;
        bit          stack_first;
        mode        = $urandom_range(0, 99);
        stack_first = 1'b0;
        if (mode < 10)
        begin
            repeat ($urandom_range(1, 8))
            begin
                tok.op    = 1'($urandom_range(0, 1));
                tok.value = VALUE_W'($urandom_range(0, 255));
                tok.last  = 1'b0;
                seq.push_back(tok);
            end
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                pushes = $urandom_range(1, 6);
            else if (r < 95)
            begin
                pushes      = $urandom_range(7, DEPTH);
                stack_first = 1'($urandom_range(0, 1));
            end
            else
            begin
                pushes      = $urandom_range(DEPTH + 1, DEPTH + 3);
                stack_first = 1'b1;
            end
            depth = 0;
            while (pushes != 0 || depth > 1)
            begin
                tok.last = 1'b0;
                if (pushes != 0 && (depth < 2 || stack_first || $urandom_range(0, 1)))
                begin
                    tok.op = 1'b0;
                    if ($urandom_range(0, 3) == 0)
                        tok.value = VALUE_W'($urandom_range(0, 4) - 2);
                    else
                        tok.value = VALUE_W'($urandom_range(0, 255));
                    pushes--;
                    depth++;
                end
                else
                begin
                    tok.op = 1'b1;
                    case ($urandom_range(0, 19))
                        0:       tok.value = VALUE_W'($urandom_range(0, 255));
                        1,2,3,4: tok.value = CODE_ADD;
                        5,6,7,8: tok.value = CODE_SUB;
                        9,10,11,12,13: tok.value = CODE_MUL;
                        default: tok.value = CODE_DIV;
                    endcase
                    depth--;
                end
                seq.push_back(tok);
            end
            // corrupt one item of some sequences
            if (mode < 25)
            begin
                idx = $urandom_range(0, seq.size() - 1);
                r   = $urandom_range(0, 2);
                if (r == 2 && seq.size() > 1)
                    seq.delete(idx);
                else if (r == 1)
                    seq[idx].value = VALUE_W'($urandom_range(0, 255));
                else
                    seq[idx].op = ~seq[idx].op;
            end
        end
        seq[seq.size()-1].last = 1'b1;
        foreach (seq[i])
            pending_tokens.push_back(seq[i]);
    endtask

    // command driver
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || cmd_fire)
        begin
            if (send_gap != 0)
            begin
                send_gap  <= send_gap - 1;
                cmd_valid <= 1'b0;
            end
            else if (pending_tokens.size() != 0)
            begin
                cmd       <= pending_tokens.pop_front();
                cmd_valid <= 1'b1;
                send_gap  <= idle_length();
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // result receiver back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                hold_left <= idle_length();
        end
    end

    // monitor: predict on accepted commands, check accepted results
    always @(posedge clk)
    begin : monitor
        bit   closes;
        rsp_t answer;
        rsp_t want;
        cycle_count <= cycle_count + 1;
        cmd_fire    <= rst_n && cmd_valid && !cmd_stall;
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            evaluate_token(cmd, closes, answer);
            if (closes)
                expected_answers.push_back(answer);
            tokens_taken++;
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("result transaction with no expression outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_answers.pop_front();
                answers_checked++;
                status_seen[want.status]++;
                if (rsp.result !== want.result)
                begin
                    $error("result: expected %0d, got %0d", want.result, rsp.result);
                    mismatches++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    mismatches++;
                end
                if (rsp.well_formed !== want.well_formed)
                begin
                    $error("well_formed: expected %0d, got %0d",
                           want.well_formed, rsp.well_formed);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("postfix_expression_evaluator_unit: mismatch");
        $finish;
    end

    // main sequence
    initial
    begin
        clear_eval();

        // all four operators with extreme operands: 127 - -128 + 7 / -2 = 252
        add_token(1'b0, 8'h7F, 1'b0);
        add_token(1'b0, 8'h80, 1'b0);
        add_token(1'b1, CODE_SUB, 1'b0);
        add_token(1'b0, 8'h07, 1'b0);
        add_token(1'b0, 8'hFE, 1'b0);
        add_token(1'b1, CODE_DIV, 1'b0);
        add_token(1'b1, CODE_ADD, 1'b1);
        // build the most negative value, then divide it by minus one
        add_token(1'b0, 8'h80, 1'b0);
        add_token(1'b0, 8'h80, 1'b0);
        add_token(1'b1, CODE_MUL, 1'b0);
        add_token(1'b0, 8'h80, 1'b0);
        add_token(1'b1, CODE_MUL, 1'b0);
        add_token(1'b0, 8'h80, 1'b0);
        add_token(1'b1, CODE_MUL, 1'b0);
        add_token(1'b0, 8'hF8, 1'b0);
        add_token(1'b1, CODE_MUL, 1'b0);
        add_token(1'b0, 8'hFF, 1'b0);
        add_token(1'b1, CODE_DIV, 1'b1);
        // operator on an empty stack
        add_token(1'b1, CODE_ADD, 1'b1);
        // unknown operator, then a push that the sticky error ignores
        add_token(1'b0, 8'h01, 1'b0);
        add_token(1'b0, 8'h02, 1'b0);
        add_token(1'b1, 8'h00, 1'b0);
        add_token(1'b0, 8'h03, 1'b1);
        // zero divisor
        add_token(1'b0, 8'h05, 1'b0);
        add_token(1'b0, 8'h00, 1'b0);
        add_token(1'b1, CODE_DIV, 1'b1);
        directed_count = pending_tokens.size();

        while (pending_tokens.size() < directed_count + RANDOM_ITEMS)
            add_random_expression();

        // reset, then let the driver run
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_tokens.size() != 0 || cmd_valid || expected_answers.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d commands (%0d directed) over %0d checked expressions, stack depth %0d",
                 tokens_taken, directed_count, answers_checked, DEPTH);
        $display("status mix: ok %0d, underflow %0d, unsupported %0d, divzero %0d, overflow %0d",
                 status_seen[STATUS_OK], status_seen[STATUS_UNDERFLOW],
                 status_seen[STATUS_UNSUPPORTED], status_seen[STATUS_DIVZERO],
                 status_seen[STATUS_OVERFLOW]);
        if (mismatches == 0)
            $display("postfix_expression_evaluator_unit: match");
        else
            $display("postfix_expression_evaluator_unit: mismatch");
        $finish;
    end

endmodule
